/* hdl/mrfw_pkg.sv */
package mrfw_pkg;

    typedef enum logic [1:0]
    {
        PHASE_RUN = 2'd0,
        PHASE_OK  = 2'd1,
        PHASE_BAD = 2'd2
    } walk_phase_t;

    localparam int unsigned CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD_BASE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_BYTES   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_MARKER    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATCH_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CODE_WORD     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CODE_HIGH     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CODE_LOW      = 3'd6;

    localparam logic [31:0] HI_BIAS       = 32'h0000_8000;
    localparam logic [31:0] HIGH_MASK     = 32'hFFFF_0000;
    localparam logic [31:0] OFFSET_STEP   = 32'd4;
    localparam logic [31:0] END_MARKER_RST = 32'hFFFF_FFFF;

    localparam int unsigned OUT_CNT_BITS = 24;

    typedef struct packed
    {
        logic        stream_last;
        logic [31:0] image_word;
        logic [31:0] stream_word;
    } mrfw_item_t;

    typedef struct packed
    {
        logic [OUT_CNT_BITS-1:0] addend_total;
        logic [OUT_CNT_BITS-1:0] range_miss_total;
        logic [OUT_CNT_BITS-1:0] kind3_total;
        logic [OUT_CNT_BITS-1:0] kind2_total;
        logic [OUT_CNT_BITS-1:0] kind1_total;
        logic [OUT_CNT_BITS-1:0] kind0_total;
        logic [OUT_CNT_BITS-1:0] fixup_total;
        walk_phase_t             walk_status;
        logic [31:0]             write_data;
        logic [31:0]             write_offset;
        logic                    write_en;
    } mrfw_result_t;

    typedef struct packed
    {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] index;
        logic [31:0]             data;
    } mrfw_cfg_t;

endpackage

/* hdl/mrfw_in_stage.sv */
module mrfw_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mrfw_pkg::mrfw_item_t in_item,
    input  logic               take,
    output logic               item_valid,
    output mrfw_pkg::mrfw_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    mrfw_pkg::mrfw_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/mrfw_step.sv */
module mrfw_step
#(
    parameter int unsigned COUNT_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrfw_pkg::mrfw_cfg_t    cfg,
    input  logic                   fire,
    input  mrfw_pkg::mrfw_item_t   item,
    output mrfw_pkg::mrfw_result_t result
);

    localparam int unsigned CW = COUNT_BITS;

    logic [31:0] load_base_reg;
    logic [31:0] image_bytes_reg;
    logic [31:0] end_marker_reg;
    logic        patch_enable_reg;
    logic [1:0]  code_word_reg;
    logic [1:0]  code_high_reg;
    logic [1:0]  code_low_reg;

    logic                  await_reg, await_next;
    logic                  skip_reg, skip_next;
    logic [31:0]           held_offset_reg, held_offset_next;
    logic [31:0]           held_word_reg, held_word_next;
    mrfw_pkg::walk_phase_t phase_reg, phase_next;
    logic [CW-1:0]         entry_reg, entry_next;
    logic [CW-1:0]         kind_reg [4];
    logic [CW-1:0]         kind_next [4];
    logic [CW-1:0]         miss_reg, miss_next;
    logic [CW-1:0]         addend_reg, addend_next;

    logic [31:0] sw;
    logic [31:0] iw;
    logic        last;
    logic [31:0] off;
    logic [1:0]  kind;
    logic        miss;
    logic [31:0] hi_sum;
    logic [31:0] jump_sum;
    logic        wen;
    logic [31:0] woff;
    logic [31:0] wdata;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        logic [CW-1:0] r;
        begin
            r = (&c) ? c : (c + {{(CW-1){1'b0}}, 1'b1});
            return r;
        end
    endfunction

    function automatic logic [mrfw_pkg::OUT_CNT_BITS-1:0] to_out(input logic [CW-1:0] c);
        logic [CW+mrfw_pkg::OUT_CNT_BITS-1:0] ext;
        begin
            ext = {{mrfw_pkg::OUT_CNT_BITS{1'b0}}, c};
            return ext[mrfw_pkg::OUT_CNT_BITS-1:0];
        end
    endfunction

    assign sw   = item.stream_word;
    assign iw   = item.image_word;
    assign last = item.stream_last;
    assign off  = {sw[31:2], 2'b00};
    assign kind = sw[1:0];
    assign miss = ({1'b0, off} + {1'b0, mrfw_pkg::OFFSET_STEP}) > {1'b0, image_bytes_reg};
    assign hi_sum   = sw + load_base_reg + mrfw_pkg::HI_BIAS;
    assign jump_sum = {4'd0, iw[25:0], 2'b00} + load_base_reg;

    always_comb
    begin
        await_next       = await_reg;
        skip_next        = skip_reg;
        held_offset_next = held_offset_reg;
        held_word_next   = held_word_reg;
        phase_next       = phase_reg;
        entry_next       = entry_reg;
        miss_next        = miss_reg;
        addend_next      = addend_reg;
        for (int k = 0; k < 4; k++)
        begin
            kind_next[k] = kind_reg[k];
        end
        wen   = 1'b0;
        woff  = 32'd0;
        wdata = 32'd0;

        if (fire && (phase_reg == mrfw_pkg::PHASE_RUN))
        begin
            if (await_reg)
            begin
                await_next  = 1'b0;
                addend_next = sat_inc(addend_reg);
                if (!skip_reg && patch_enable_reg)
                begin
                    wen   = 1'b1;
                    woff  = held_offset_reg;
                    wdata = (held_word_reg & mrfw_pkg::HIGH_MASK) | {16'd0, hi_sum[31:16]};
                end
                skip_next = 1'b0;
                if (last)
                begin
                    phase_next = mrfw_pkg::PHASE_BAD;
                end
            end
            else if (sw == end_marker_reg)
            begin
                phase_next = mrfw_pkg::PHASE_OK;
            end
            else
            begin
                entry_next = sat_inc(entry_reg);
                for (int k = 0; k < 4; k++)
                begin
                    if (kind == k[1:0])
                    begin
                        kind_next[k] = sat_inc(kind_reg[k]);
                    end
                end
                if (miss)
                begin
                    miss_next = sat_inc(miss_reg);
                    if ((kind == code_high_reg) && (kind != code_word_reg) && !last)
                    begin
                        await_next = 1'b1;
                        skip_next  = 1'b1;
                    end
                end
                else if (kind == code_word_reg)
                begin
                    wen   = patch_enable_reg;
                    wdata = iw + load_base_reg;
                end
                else if (kind == code_high_reg)
                begin
                    if (!last)
                    begin
                        await_next       = 1'b1;
                        skip_next        = 1'b0;
                        held_offset_next = off;
                        held_word_next   = iw;
                    end
                end
                else if (kind == code_low_reg)
                begin
                    wen   = patch_enable_reg;
                    wdata = {iw[31:16], iw[15:0] + load_base_reg[15:0]};
                end
                else
                begin
                    wen   = patch_enable_reg;
                    wdata = {iw[31:26], jump_sum[27:2]};
                end
                if (wen)
                begin
                    woff = off;
                end
                else
                begin
                    wdata = 32'd0;
                end
                if (last)
                begin
                    phase_next = mrfw_pkg::PHASE_BAD;
                end
            end
        end
    end

    always_comb
    begin
        result.write_en         = wen;
        result.write_offset     = woff;
        result.write_data       = wdata;
        result.walk_status      = phase_next;
        result.fixup_total      = to_out(entry_next);
        result.kind0_total      = to_out(kind_next[0]);
        result.kind1_total      = to_out(kind_next[1]);
        result.kind2_total      = to_out(kind_next[2]);
        result.kind3_total      = to_out(kind_next[3]);
        result.range_miss_total = to_out(miss_next);
        result.addend_total     = to_out(addend_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg    <= 32'd0;
            image_bytes_reg  <= 32'd0;
            end_marker_reg   <= mrfw_pkg::END_MARKER_RST;
            patch_enable_reg <= 1'b1;
            code_word_reg    <= 2'd0;
            code_high_reg    <= 2'd1;
            code_low_reg     <= 2'd2;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                mrfw_pkg::CFG_LOAD_BASE:    load_base_reg    <= cfg.data;
                mrfw_pkg::CFG_IMAGE_BYTES:  image_bytes_reg  <= cfg.data;
                mrfw_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg.data;
                mrfw_pkg::CFG_PATCH_ENABLE: patch_enable_reg <= cfg.data[0];
                mrfw_pkg::CFG_CODE_WORD:    code_word_reg    <= cfg.data[1:0];
                mrfw_pkg::CFG_CODE_HIGH:    code_high_reg    <= cfg.data[1:0];
                mrfw_pkg::CFG_CODE_LOW:     code_low_reg     <= cfg.data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg       <= 1'b0;
            skip_reg        <= 1'b0;
            held_offset_reg <= 32'd0;
            held_word_reg   <= 32'd0;
            phase_reg       <= mrfw_pkg::PHASE_RUN;
            entry_reg       <= '0;
            miss_reg        <= '0;
            addend_reg      <= '0;
            for (int k = 0; k < 4; k++)
            begin
                kind_reg[k] <= '0;
            end
        end
        else
        begin
            await_reg       <= await_next;
            skip_reg        <= skip_next;
            held_offset_reg <= held_offset_next;
            held_word_reg   <= held_word_next;
            phase_reg       <= phase_next;
            entry_reg       <= entry_next;
            miss_reg        <= miss_next;
            addend_reg      <= addend_next;
            for (int k = 0; k < 4; k++)
            begin
                kind_reg[k] <= kind_next[k];
            end
        end
    end

endmodule

/* hdl/mips_reloc_fixup_walker.sv */
// The result of a transaction accepted on the slave side passes through the input register and
// the result register before it is offered on the master side.
// One transaction per cycle unless m_tready stalls the output; walk state is updated per word.
// Two registers (input and result) let a new word be accepted while a result waits.
// Reset clears the walk state, all counters and the valid flags of both registers, and sets
// every configuration register to its default value.
module mips_reloc_fixup_walker
#(
    parameter int unsigned COUNT_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // stream_word[31:0], image_word[63:32]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,  // write_offset, write_data, walk_status, fixup_total,
                                   // kind0_total .. kind3_total, range_miss_total,
                                   // addend_total, zero fill
    output logic         m_tuser   // write_en
);

    mrfw_pkg::mrfw_item_t   in_item;
    mrfw_pkg::mrfw_item_t   item;
    mrfw_pkg::mrfw_cfg_t    cfg;
    mrfw_pkg::mrfw_result_t result;
    mrfw_pkg::mrfw_result_t out_reg;
    logic                   item_valid;
    logic                   take;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    assign in_item.stream_word = s_tdata[31:0];
    assign in_item.image_word  = s_tdata[63:32];
    assign in_item.stream_last = s_tlast;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign take = !out_valid_reg || m_tready;

    mrfw_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mrfw_step #(.COUNT_BITS(COUNT_BITS)) u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (item_valid && take),
        .item   (item),
        .result (result)
    );

    assign out_valid_next = take ? item_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && take)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.write_en;
    assign m_tdata  = {6'd0,
                       out_reg.addend_total,
                       out_reg.range_miss_total,
                       out_reg.kind3_total,
                       out_reg.kind2_total,
                       out_reg.kind1_total,
                       out_reg.kind0_total,
                       out_reg.fixup_total,
                       out_reg.walk_status,
                       out_reg.write_data,
                       out_reg.write_offset};

endmodule

/* hdl/mrfw_checker.sv */
module mrfw_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata,
    input logic         m_tuser
);

    // A reported status is never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[65:64] != 2'd3))
        else $error("walk status carries an unused code");

    // A transaction without a write carries zero offset and zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> ((m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == 32'd0)))
        else $error("offset or data set on a transaction without a write");

    // A write only targets a word-aligned offset, and only while running or at the final word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata[1:0] == 2'b00) && (m_tdata[65:64] != 2'd1)))
        else $error("misaligned write or write on a terminated walk");

    // A stalled result stays on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before it was taken");

endmodule

bind mips_reloc_fixup_walker mrfw_checker u_mrfw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
